// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the keyed counter table.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define KCT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When ante holds, cons must hold in the following cycle.
`define KCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kct_pkg.sv =====
// Package of the keyed counter table: field widths, command codes and the
// request token that travels down the chain of cells. No dependencies.
`default_nettype none

package kct_pkg;

  localparam int unsigned KEY_W       = 31;
  localparam int unsigned CNT_W       = 31;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ENTRIES_DEF = 64;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Request as it moves from cell to cell.
  typedef struct packed {
    logic             vld;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic             hit;
    logic             free_found;
    logic [CNT_W-1:0] value;
  } tok_t;

  // Insert broadcast: taken by the cell that claimed the lowest free entry.
  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } ins_t;

endpackage

`default_nettype wire

// ===== rtl/kct_in_if.sv =====
// Request channel of the keyed counter table: valid/ready plus payload.
// Depends on kct_pkg for field widths.
`default_nettype none

interface kct_in_if;
  logic                        valid;
  logic                        ready;
  logic [kct_pkg::CMD_W-1:0]   cmd;
  logic [kct_pkg::KEY_W-1:0]   key;
  logic [kct_pkg::CNT_W-1:0]   count;

  modport source (output valid, output cmd, output key, output count, input ready);
  modport sink   (input valid, input cmd, input key, input count, output ready);
endinterface

`default_nettype wire

// ===== rtl/kct_out_if.sv =====
// Result channel of the keyed counter table: valid/ready plus payload.
// Depends on kct_pkg for field widths.
`default_nettype none

interface kct_out_if;
  logic                        valid;
  logic                        ready;
  logic [kct_pkg::CNT_W-1:0]   value;
  logic                        ok;
  logic                        full_res;

  modport source (output valid, output value, output ok, output full_res, input ready);
  modport sink   (input valid, input value, input ok, input full_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/kct_cell.sv =====
// One table entry: key, count and valid mark, plus one stage of the request
// chain. Depends on kct_pkg for the token and insert types.
`default_nettype none

module kct_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire kct_pkg::tok_t tok_i,
  input  wire kct_pkg::ins_t ins_i,
  output kct_pkg::tok_t      tok_o
);

  logic                        valid_r;
  logic                        cand_r;
  logic [kct_pkg::KEY_W-1:0]   key_r;
  logic [kct_pkg::CNT_W-1:0]   count_r;
  kct_pkg::tok_t               tok_r;
  kct_pkg::tok_t               tok_nxt;
  logic [kct_pkg::CNT_W-1:0]   count_nxt;
  logic                        match;
  logic                        claim;
  logic                        cnt_wr;

  always_comb begin
    match = tok_i.vld && valid_r && (key_r == tok_i.key);
    // lowest free entry on this pass
    claim = tok_i.vld && !valid_r && !tok_i.free_found;
    cnt_wr = match && ((tok_i.cmd == kct_pkg::CMD_ADD) || (tok_i.cmd == kct_pkg::CMD_SET));
    case (tok_i.cmd)
      kct_pkg::CMD_ADD: count_nxt = (count_r == kct_pkg::CNT_MAX) ? count_r
                                    : count_r + kct_pkg::CNT_W'(1);
      kct_pkg::CMD_SET: count_nxt = tok_i.count;
      default:          count_nxt = count_r;
    endcase
    tok_nxt = tok_i;
    if (match) begin
      tok_nxt.hit   = 1'b1;
      tok_nxt.value = count_nxt;
    end
    if (tok_i.vld && !valid_r) begin
      tok_nxt.free_found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= 1'b0;
    end else begin
      if (tok_i.vld) begin
        cand_r <= claim;
      end
      if (ins_i.en && cand_r) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins_i.en && cand_r) begin
      key_r   <= ins_i.key;
      count_r <= ins_i.count;
    end else if (cnt_wr) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

// ===== rtl/keyed_counter_table.sv =====
// Keyed counter table: a chain of ENTRIES cells; each request walks the chain
// one cell per cycle, then a possible insert is broadcast to the claimed cell.
// The request is registered at launch, then in each cell in turn, and the result is registered.
// Throughput is set by the chain walk: a new request is taken only once the walk is done
// and the previous result has been taken.
// Reset (synchronous, rst_n low) clears all valid marks; keys and counts are not reset.
`default_nettype none
`include "assert_macros.svh"

module keyed_counter_table #(
  parameter int unsigned ENTRIES = kct_pkg::ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  kct_in_if.sink    in_ch,
  kct_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                      state_r, state_nxt;
  kct_pkg::tok_t               launch_r;
  kct_pkg::tok_t               tok_w [ENTRIES+1];
  kct_pkg::tok_t               tok_end;
  kct_pkg::ins_t               ins;
  logic                        in_ready;
  logic                        in_acc;
  logic                        out_valid_r;
  logic [kct_pkg::CNT_W-1:0]   out_value_r, res_value;
  logic                        out_ok_r, res_ok;
  logic                        out_full_r, res_full;

  assign in_ready    = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r.vld <= 1'b0;
    end else begin
      launch_r.vld        <= in_acc;
      launch_r.cmd        <= in_ch.cmd;
      launch_r.key        <= in_ch.key;
      launch_r.count      <= in_ch.count;
      launch_r.hit        <= 1'b0;
      launch_r.free_found <= 1'b0;
      launch_r.value      <= '0;
    end
  end

  assign tok_w[0] = launch_r;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kct_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok_w[i]),
      .ins_i (ins),
      .tok_o (tok_w[i+1])
    );
  end

  assign tok_end = tok_w[ENTRIES];

  // Resolve the request once it leaves the last cell.
  always_comb begin
    res_value  = '0;
    res_ok     = 1'b0;
    res_full   = 1'b0;
    ins.en     = 1'b0;
    ins.key    = tok_end.key;
    ins.count  = (tok_end.cmd == kct_pkg::CMD_ADD) ? kct_pkg::CNT_W'(1) : tok_end.count;
    case (tok_end.cmd)
      kct_pkg::CMD_ADD, kct_pkg::CMD_SET: begin
        if (tok_end.hit) begin
          res_value = tok_end.value;
          res_ok    = 1'b1;
        end else if (tok_end.free_found) begin
          res_value = ins.count;
          res_ok    = 1'b1;
          ins.en    = tok_end.vld;
        end else begin
          res_full  = 1'b1;
        end
      end
      kct_pkg::CMD_GET: begin
        res_value = tok_end.value;
        res_ok    = 1'b1;
      end
      default: begin
        res_value = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_RUN;
      S_RUN:   if (tok_end.vld) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (tok_end.vld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_end.vld) begin
      out_value_r <= res_value;
      out_ok_r    <= res_ok;
      out_full_r  <= res_full;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.ok       = out_ok_r;
  assign out_ch.full_res = out_full_r;

  `KCT_ASSERT(a_end_only_in_run, !tok_end.vld || (state_r == S_RUN), "token left chain while idle")
  `KCT_ASSERT(a_run_out_empty, (state_r != S_RUN) || !out_valid_r, "result pending during a walk")
  `KCT_ASSERT(a_full_not_ok, !out_valid_r || !(out_full_r && out_ok_r), "full result marked ok")
  `KCT_ASSERT_NEXT(a_launch, in_acc, launch_r.vld && (state_r == S_RUN), "accepted request not launched")

endmodule

`default_nettype wire
